// ----- hw/rtl/fsc_pkg.sv -----
// fsc_pkg: shared constants and types for the framed sum check receiver
// no dependencies; imported by fsc_slotq, fsc_front, fsc_back and the top level
package fsc_pkg;

    localparam int BYTE_W        = 8;
    localparam int POS_W         = 6;
    localparam int SUM_W         = 16;
    localparam int FRAME_LEN_DEF = 32;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h3A;
    localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;

    // state of the two frame slots shared by front and back
    typedef struct packed {
        logic full;
        logic empty;
        logic wr_slot;
        logic rd_slot;
    } fsc_slot_status_t;

endpackage

// ----- hw/rtl/fsc_ram.sv -----
// fsc_ram: generic single write port, single read port ram with registered read
// no dependencies
module fsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fsc_slotq.sv -----
// fsc_slotq: two-entry queue of finished frame slots between front and back
// depends on fsc_pkg for the slot status struct
module fsc_slotq
    import fsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             pop,
    output fsc_slot_status_t status
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    assign status.full    = (count_reg == 2'd2);
    assign status.empty   = (count_reg == 2'd0);
    assign status.wr_slot = wr_ptr_reg;
    assign status.rd_slot = rd_ptr_reg;

endmodule

// ----- hw/rtl/fsc_front.sv -----
// fsc_front: header hunt, frame capture into the slot ram and running checksum
// depends on fsc_pkg for byte constants and the slot status struct
module fsc_front
    import fsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [BYTE_W-1:0]                  rx_byte,
    input  fsc_slot_status_t                   status,
    output logic                               push,
    output logic                               wr_en,
    output logic [$clog2(FRAME_LEN):0]         wr_addr,
    output logic [BYTE_W-1:0]                  wr_data
);

    localparam int PW = $clog2(FRAME_LEN);
    localparam int FW = $clog2(FRAME_LEN + 1);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_TAIL = 4'b0100,
        PH_DONE = 4'b1000
    } fsc_phase_t;

    fsc_phase_t       phase_reg, phase_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] want_reg, want_next;
    logic             accept;
    logic             store;

    // the slot being filled must not still wait for read-out
    assign in_ready = !status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        want_next  = want_reg;
        store      = 1'b0;
        push       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_BYTE)
                    begin
                        phase_next = PH_BODY;
                        store      = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (rx_byte == CR_BYTE && fill_reg == FW'(FRAME_LEN - 2))
                    begin
                        phase_next = PH_TAIL;
                        store      = 1'b1;
                    end
                    else if (fill_reg != FW'(FRAME_LEN))
                    begin
                        store = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                    end
                end
                PH_TAIL:
                begin
                    if (rx_byte == LF_BYTE && fill_reg == FW'(FRAME_LEN - 1))
                    begin
                        phase_next = PH_DONE;
                        store      = 1'b1;
                    end
                    else if (fill_reg != FW'(FRAME_LEN))
                    begin
                        store = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                    end
                end
                PH_DONE:
                begin
                    // trailing word is dropped; the check decides on it
                    push       = (sum_reg == want_reg);
                    phase_next = PH_HUNT;
                    fill_next  = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    fill_next  = '0;
                end
            endcase
        end

        if (store)
        begin
            fill_next = fill_reg + FW'(1);
            if (fill_reg == '0)
            begin
                sum_next = '0;
            end
            else if (fill_reg <= FW'(FRAME_LEN - 5))
            begin
                sum_next = sum_reg + SUM_W'(rx_byte);
            end
            if (fill_reg == FW'(FRAME_LEN - 4))
            begin
                want_next[7:0] = rx_byte;
            end
            if (fill_reg == FW'(FRAME_LEN - 3))
            begin
                want_next[15:8] = rx_byte;
            end
        end
    end

    assign wr_en   = store;
    assign wr_addr = {status.wr_slot, fill_reg[PW-1:0]};
    assign wr_data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        want_reg <= want_next;
    end

endmodule

// ----- hw/rtl/fsc_back.sv -----
// fsc_back: reads a checked frame out of its slot, one word per cycle while out_ready is high
// depends on fsc_pkg for widths and the slot status struct
module fsc_back
    import fsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fsc_slot_status_t           status,
    output logic                       pop,
    output logic                       rd_en,
    output logic [$clog2(FRAME_LEN):0] rd_addr,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [POS_W-1:0]           byte_position,
    output logic                       last
);

    localparam int PW = $clog2(FRAME_LEN);
    localparam int FW = $clog2(FRAME_LEN + 1);

    logic [FW-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg;
    logic             last_reg;
    logic             valid_reg, valid_next;
    logic             out_take;

    assign out_take = valid_reg && out_ready;
    // ram output is the payload register, so a read only goes out when it is free
    assign rd_en    = !status.empty && (cnt_reg != FW'(FRAME_LEN))
                      && (!valid_reg || out_ready);
    assign rd_addr  = {status.rd_slot, cnt_reg[PW-1:0]};
    assign pop      = out_take && last_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (rd_en)
        begin
            cnt_next   = cnt_reg + FW'(1);
            valid_next = 1'b1;
        end
        else if (out_take)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            if (rd_en)
            begin
                last_reg <= (cnt_reg == FW'(FRAME_LEN - 1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pos_reg <= POS_W'(cnt_reg);
        end
    end

    assign out_valid     = valid_reg;
    assign byte_position = pos_reg;
    assign last          = last_reg;

endmodule

// ----- hw/rtl/framed_sum_check_receiver.sv -----
// framed_sum_check_receiver: top level of the framed additive checksum receiver
// depends on fsc_pkg, fsc_ram, fsc_front, fsc_slotq and fsc_back
//
// Input channel (in_valid, in_ready, rx_byte) takes one received byte per
// word. The front hunts for the 0x3A header, stores FRAME_LEN bytes ending in
// 0x0D 0x0A into one of two frame slots of a ram and sums the body as it goes.
// The byte after the 0x0A is consumed and dropped; on it the sum is compared
// with the little-endian word before the 0x0D.
// Output channel (out_valid, out_ready, frame_byte, byte_position, last)
// gives a passing frame as FRAME_LEN words, last set on the final one.
// Input takes one word per cycle while in_ready is high. With the read-out
// side idle, a passing frame's first word leaves the ram's registered read
// once the trailing byte is accepted, then one word per cycle while out_ready
// is high; the read-out rate is set by the single read port of the slot ram.
// A stalled receiver holds the current word. The front keeps filling the
// other slot; in_ready drops only when both slots hold frames waiting for
// read-out. Reset returns the front to hunting and empties the slot queue;
// ram contents are not cleared.
module framed_sum_check_receiver
    import fsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] frame_byte,
    output logic [POS_W-1:0]  byte_position,
    output logic              last
);

    localparam int AW        = $clog2(FRAME_LEN) + 1;
    localparam int RAM_DEPTH = 2 ** AW;

    fsc_slot_status_t  status;
    logic              push;
    logic              pop;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    fsc_front #(
        .FRAME_LEN(FRAME_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .status   (status),
        .push     (push),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    fsc_slotq u_slotq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status)
    );

    fsc_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (frame_byte)
    );

    fsc_back #(
        .FRAME_LEN(FRAME_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (status),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_position (byte_position),
        .last          (last)
    );

`ifndef SYNTH
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> byte_position == POS_W'(FRAME_LEN - 1))
        else $error("last word not at final frame position");

    a_first_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_position == '0 |-> frame_byte == HDR_BYTE)
        else $error("frame read-out does not start with header");

    a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_byte == LF_BYTE)
        else $error("frame read-out does not end with line feed");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> out_valid && byte_position == $past(byte_position) + POS_W'(1))
        else $error("frame read-out skipped or stalled mid-frame");
`endif

endmodule
